// ----- rtl/core/sap_hp_pkg.sv -----
// ----------------------------------------------------------------------------
// SAP header parser package
// Word types, phase and status codes and the payload type text that are
// shared by the parser core.
// ----------------------------------------------------------------------------
package sap_hp_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned TYPE_LEN        = 15;
  localparam int unsigned OUT_OFF_W       = 16;

  // Parse phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_ORIG4  = 3'd1;
  localparam logic [2:0] PH_ORIG6  = 3'd2;
  localparam logic [2:0] PH_AUTH   = 3'd3;
  localparam logic [2:0] PH_TYPE   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_IPV6    = 2'd2;
  localparam logic [1:0] ST_UNTERM  = 2'd3;

  // Progress through the implicit "v=0" check; ICHK_FAIL once it has failed.
  localparam logic [1:0] ICHK_FAIL = 2'd3;

  localparam logic [7:0] CH_V    = 8'h76;
  localparam logic [7:0] CH_EQ   = 8'h3d;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  version;
    logic        addr_is_v6;
    logic        is_deletion;
    logic        encrypted_flag;
    logic        compressed_flag;
    logic [7:0]  auth_words;
    logic [15:0] message_id;
    logic [31:0] origin_ipv4;
    logic [15:0] payload_offset;
    logic        type_implicit;
    logic        payload_is_sdp;
  } out_word_t;

  // Characters of "application/sdp"; the index past the end gives NUL.
  function automatic logic [7:0] sdp_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h61;
      4'd1:    c = 8'h70;
      4'd2:    c = 8'h70;
      4'd3:    c = 8'h6c;
      4'd4:    c = 8'h69;
      4'd5:    c = 8'h63;
      4'd6:    c = 8'h61;
      4'd7:    c = 8'h74;
      4'd8:    c = 8'h69;
      4'd9:    c = 8'h6f;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h2f;
      4'd12:   c = 8'h73;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h70;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] implicit_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_V;
      2'd1:    c = CH_EQ;
      2'd2:    c = CH_ZERO;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/sap_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// SAP header parser core
// Parses a SAP announcement one byte per word and gives one result word per
// datagram: the header fields and payload offset, or an error status.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Word type  | Handshake
//   in_     | input     | in_word_t  | in_valid / in_ready
//   out_    | output    | out_word_t | out_valid / out_ready
//
// One byte is taken per cycle; the parse state advances in the accepting cycle
// and a result appears in the output register on the following cycle.
// Throughput is one word per cycle while the output register is empty or
// being drained in the same cycle.
// A stalled output register holds its word and holds off the input.
// Reset is synchronous and puts the parser at the start of a datagram.
// ----------------------------------------------------------------------------
module sap_header_parser_core #(
  parameter int unsigned OFFSET_BITS = sap_hp_pkg::OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sap_hp_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sap_hp_pkg::out_word_t out_data
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX      = '1;
  localparam logic [OFFSET_BITS-1:0] POS_HDR_END  = OFFSET_BITS'(3);
  localparam logic [OFFSET_BITS-1:0] POS_ORG4_END = OFFSET_BITS'(7);
  localparam logic [OFFSET_BITS-1:0] POS_ORG6_END = OFFSET_BITS'(19);
  localparam logic [3:0]             TYPE_END     = 4'(sap_hp_pkg::TYPE_LEN);

  logic [2:0]             phase_r,  phase_nxt;
  logic [OFFSET_BITS-1:0] pos_r,    pos_nxt;
  logic [9:0]             skip_r,   skip_nxt;
  logic [31:0]            hdr_r,    hdr_nxt;
  logic [31:0]            orig_r,   orig_nxt;
  logic [3:0]             tidx_r,   tidx_nxt;
  logic                   tok_r,    tok_nxt;
  logic [1:0]             ichk_r,   ichk_nxt;
  logic                   done_r,   done_nxt;
  logic                   out_valid_r;
  sap_hp_pkg::out_word_t  out_data_r;

  logic                   accept;
  logic                   emit;
  logic [1:0]             e_status;
  logic [31:0]            e_origin;
  logic [OFFSET_BITS-1:0] e_off;
  logic                   e_impl;
  logic                   e_sdp;
  logic [31:0]            hdr_emit;
  logic [7:0]             b;
  logic [7:0]             b0;
  logic [31:0]            off_wide;
  sap_hp_pkg::out_word_t  out_nxt;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.pkt_byte;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    skip_nxt  = skip_r;
    hdr_nxt   = hdr_r;
    orig_nxt  = orig_r;
    tidx_nxt  = tidx_r;
    tok_nxt   = tok_r;
    ichk_nxt  = ichk_r;
    done_nxt  = done_r;
    emit      = 1'b0;
    e_status  = sap_hp_pkg::ST_OK;
    e_origin  = '0;
    e_off     = '0;
    e_impl    = 1'b0;
    e_sdp     = 1'b0;

    if (!done_r) begin
      case (phase_r)
        sap_hp_pkg::PH_HEADER: begin
          case (pos_r[1:0])
            2'd0:    hdr_nxt = hdr_r | {b, 24'd0};
            2'd1:    hdr_nxt = hdr_r | {8'd0, b, 16'd0};
            2'd2:    hdr_nxt = hdr_r | {16'd0, b, 8'd0};
            default: hdr_nxt = hdr_r | {24'd0, b};
          endcase
          if (pos_r >= POS_HDR_END) begin
            phase_nxt = hdr_nxt[28] ? sap_hp_pkg::PH_ORIG6 : sap_hp_pkg::PH_ORIG4;
          end
        end
        sap_hp_pkg::PH_ORIG4: begin
          orig_nxt = {orig_r[23:0], b};
          if (pos_r >= POS_ORG4_END) begin
            skip_nxt  = {hdr_r[23:16], 2'b00};
            phase_nxt = (hdr_r[23:16] == 8'd0) ? sap_hp_pkg::PH_TYPE : sap_hp_pkg::PH_AUTH;
          end
        end
        sap_hp_pkg::PH_ORIG6: begin
          if (pos_r >= POS_ORG6_END) begin
            emit     = 1'b1;
            e_status = sap_hp_pkg::ST_IPV6;
            done_nxt = 1'b1;
          end
        end
        sap_hp_pkg::PH_AUTH: begin
          skip_nxt = skip_r - 10'd1;
          if (skip_nxt == 10'd0) begin
            phase_nxt = sap_hp_pkg::PH_TYPE;
          end
        end
        default: begin
          if (ichk_r != sap_hp_pkg::ICHK_FAIL) begin
            if (b == sap_hp_pkg::implicit_char(ichk_r)) begin
              if (ichk_r == 2'd2) begin
                emit     = 1'b1;
                e_status = sap_hp_pkg::ST_OK;
                e_origin = orig_r;
                e_off    = pos_r - OFFSET_BITS'(2);
                e_impl   = 1'b1;
                e_sdp    = 1'b1;
                done_nxt = 1'b1;
              end else begin
                ichk_nxt = ichk_r + 2'd1;
              end
            end else begin
              ichk_nxt = sap_hp_pkg::ICHK_FAIL;
            end
          end
          if (!emit) begin
            if (b == 8'd0) begin
              emit     = 1'b1;
              e_status = sap_hp_pkg::ST_OK;
              e_origin = orig_r;
              e_off    = (pos_r != POS_MAX) ? pos_r + OFFSET_BITS'(1) : pos_r;
              e_sdp    = tok_r && (tidx_r == TYPE_END);
              done_nxt = 1'b1;
            end else if (tok_r && (tidx_r != TYPE_END) &&
                         (b == sap_hp_pkg::sdp_char(tidx_r))) begin
              tidx_nxt = tidx_r + 4'd1;
            end else begin
              tok_nxt = 1'b0;
            end
          end
        end
      endcase

      if (!emit && in_data.last_byte) begin
        emit     = 1'b1;
        e_status = (phase_nxt == sap_hp_pkg::PH_TYPE) ? sap_hp_pkg::ST_UNTERM
                                                       : sap_hp_pkg::ST_TRUNC;
      end
    end

    hdr_emit = hdr_nxt;

    if (in_data.last_byte) begin
      phase_nxt = sap_hp_pkg::PH_HEADER;
      pos_nxt   = '0;
      skip_nxt  = '0;
      hdr_nxt   = '0;
      orig_nxt  = '0;
      tidx_nxt  = '0;
      tok_nxt   = 1'b1;
      ichk_nxt  = '0;
      done_nxt  = 1'b0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + OFFSET_BITS'(1);
    end
  end

  assign b0       = hdr_emit[31:24];
  assign off_wide = 32'(e_off);

  always_comb begin
    out_nxt.status          = e_status;
    out_nxt.version         = b0[7:5];
    out_nxt.addr_is_v6      = b0[4];
    out_nxt.is_deletion     = b0[2];
    out_nxt.encrypted_flag  = b0[1];
    out_nxt.compressed_flag = b0[0];
    out_nxt.auth_words      = hdr_emit[23:16];
    out_nxt.message_id      = hdr_emit[15:0];
    out_nxt.origin_ipv4     = e_origin;
    out_nxt.payload_offset  = off_wide[sap_hp_pkg::OUT_OFF_W-1:0];
    out_nxt.type_implicit   = e_impl;
    out_nxt.payload_is_sdp  = e_sdp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sap_hp_pkg::PH_HEADER;
      pos_r       <= '0;
      skip_r      <= '0;
      hdr_r       <= '0;
      orig_r      <= '0;
      tidx_r      <= '0;
      tok_r       <= 1'b1;
      ichk_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        skip_r  <= skip_nxt;
        hdr_r   <= hdr_nxt;
        orig_r  <= orig_nxt;
        tidx_r  <= tidx_nxt;
        tok_r   <= tok_nxt;
        ichk_r  <= ichk_nxt;
        done_r  <= done_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_byte |=> pos_r == '0 && phase_r == sap_hp_pkg::PH_HEADER)
    else $error("A final byte did not restart the parser.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("Input taken while a result word is stalled.");

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != sap_hp_pkg::ST_OK |->
      out_data_r.origin_ipv4 == '0 && out_data_r.payload_offset == '0 &&
      !out_data_r.payload_is_sdp)
    else $error("Error result carries payload fields.");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> phase_r == sap_hp_pkg::PH_TYPE || phase_r == sap_hp_pkg::PH_ORIG6)
    else $error("Datagram finished in an unexpected phase.");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done_r |-> !emit)
    else $error("Result produced after the datagram was finished.");
`endif

endmodule
